FILE: rtl/subsequence_occurrence_counter_assert.svh
// Assertion macros used by the subsequence occurrence counter checker.
// Every macro samples on the rising clock edge and is disabled while reset is high.
`ifndef SUBSEQUENCE_OCCURRENCE_COUNTER_ASSERT_SVH
`define SUBSEQUENCE_OCCURRENCE_COUNTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SOC_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SOC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/soc_pkg.sv
// Shared types and constants for the subsequence occurrence counter.
// This package has no dependencies. The controller, datapath and top level use it.
package soc_pkg;

   localparam int WORD_BITS = 16;
   localparam int LEN_W     = 5;
   localparam int COUNT_W   = 14;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [LEN_W-1:0]     len_type;
   typedef logic [COUNT_W-1:0]   count_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // These are the commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic step;
      logic emit;
   } cmd_type;

   // This is the status from the datapath to the controller.
   typedef struct packed {
      logic steps_done;
   } status_type;

endpackage

FILE: rtl/subsequence_occurrence_counter.sv
// Subsequence occurrence counter: an item is loaded, the row of counts is updated once per
// sent bit for L sent bits, where L is sent_len capped at the smaller of MAX_LEN and 16, and
// the count is then emitted into the result register once that register is free.
// Results leave through an output register, so a new item is taken while a result waits.
// Reset is synchronous and active high. It clears the controller state and the result
// valid flag. The row and word registers are loaded with each item and are not reset.
module subsequence_occurrence_counter #(
   parameter int MAX_LEN = 16
) (
   input  logic                clock,
   input  logic                reset,
   // This is the input item channel.
   input  logic                req_valid,
   output logic                req_stall,
   input  soc_pkg::word_type   req_sent_bits,
   input  soc_pkg::len_type    req_sent_len,
   input  soc_pkg::word_type   req_received_bits,
   input  soc_pkg::len_type    req_received_len,
   // This is the result item channel.
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output soc_pkg::count_type  rsp_occurrence_count
);

   // The controller and datapath talk only through these command and status groups.
   soc_pkg::cmd_type    cmd;
   soc_pkg::status_type status;

   // The controller accepts an item in idle, steps the row until every sent bit is used,
   // and then moves the count into the result register once that register is free.
   soc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath aligns both words to their first symbol, holds the row of counts indexed
   // by received prefix length, and updates every entry above the first in parallel on each step.
   soc_dpath #(
      .MAX_LEN (MAX_LEN)
   ) u_dpath (
      .clock                (clock),
      .cmd                  (cmd),
      .status               (status),
      .req_sent_bits        (req_sent_bits),
      .req_sent_len         (req_sent_len),
      .req_received_bits    (req_received_bits),
      .req_received_len     (req_received_len),
      .rsp_occurrence_count (rsp_occurrence_count)
   );

endmodule

FILE: rtl/soc_ctrl.sv
// Controller state machine for the subsequence occurrence counter.
// It depends on soc_pkg and drives the soc_dpath commands.
module soc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  soc_pkg::status_type   status,
   output soc_pkg::cmd_type      cmd
);

   soc_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= soc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The result register can be loaded once it is empty or is being taken.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      req_stall    = 1'b1;
      case (state_ff)
         soc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = soc_pkg::ST_RUN;
            end
         end
         soc_pkg::ST_RUN: begin
            if (!status.steps_done) begin
               cmd.step = 1'b1;
            end else if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = soc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = soc_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/soc_dpath.sv
// Datapath for the subsequence occurrence counter: aligned words, the row of counts and the result.
// It depends on soc_pkg and is driven by soc_ctrl commands.
module soc_dpath #(
   parameter int MAX_LEN = 16
) (
   input  logic                  clock,
   input  soc_pkg::cmd_type      cmd,
   output soc_pkg::status_type   status,
   input  soc_pkg::word_type     req_sent_bits,
   input  soc_pkg::len_type      req_sent_len,
   input  soc_pkg::word_type     req_received_bits,
   input  soc_pkg::len_type      req_received_len,
   output soc_pkg::count_type    rsp_occurrence_count
);

   localparam int LIM   = (MAX_LEN < soc_pkg::WORD_BITS) ? MAX_LEN : soc_pkg::WORD_BITS;
   localparam int IDX_W = $clog2(LIM + 1);
   localparam soc_pkg::len_type LEN_CAP   = soc_pkg::len_type'(LIM);
   localparam soc_pkg::len_type WORD_LEN  = soc_pkg::len_type'(soc_pkg::WORD_BITS);

   soc_pkg::len_type   slen_lim, rlen_lim;
   soc_pkg::word_type  sent_al, recv_al;

   soc_pkg::word_type  sent_ff, recv_ff;
   soc_pkg::len_type   rlen_ff, cnt_ff;
   soc_pkg::count_type row_ff [LIM+1];
   soc_pkg::count_type row_in [LIM+1];
   soc_pkg::count_type result_ff;

   assign slen_lim = (req_sent_len > LEN_CAP) ? LEN_CAP : req_sent_len;
   assign rlen_lim = (req_received_len > LEN_CAP) ? LEN_CAP : req_received_len;

   // Each word is moved up so that its first symbol sits in the top bit.
   assign sent_al = soc_pkg::word_type'(req_sent_bits << (WORD_LEN - slen_lim));
   assign recv_al = soc_pkg::word_type'(req_received_bits << (WORD_LEN - rlen_lim));

   // Every entry but the first adds its left neighbor when its received symbol matches the sent bit.
   always_comb begin
      row_in[0] = row_ff[0];
      for (int j = 1; j <= LIM; j++) begin
         if (recv_ff[soc_pkg::WORD_BITS-j] == sent_ff[soc_pkg::WORD_BITS-1]) begin
            row_in[j] = soc_pkg::count_type'(row_ff[j] + row_ff[j-1]);
         end else begin
            row_in[j] = row_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sent_ff <= sent_al;
         recv_ff <= recv_al;
         rlen_ff <= rlen_lim;
         cnt_ff  <= slen_lim;
         row_ff[0] <= soc_pkg::count_type'(1);
         for (int j = 1; j <= LIM; j++) begin
            row_ff[j] <= '0;
         end
      end else if (cmd.step) begin
         sent_ff <= soc_pkg::word_type'(sent_ff << 1);
         cnt_ff  <= cnt_ff - soc_pkg::len_type'(1);
         row_ff  <= row_in;
      end
      if (cmd.emit) begin
         result_ff <= row_ff[rlen_ff[IDX_W-1:0]];
      end
   end

   assign status.steps_done   = (cnt_ff == '0);
   assign rsp_occurrence_count = result_ff;

endmodule

FILE: rtl/soc_checker.sv
// Port-level checker for the subsequence occurrence counter, with its bind statement.
// It depends on soc_pkg and on the assertion macros in subsequence_occurrence_counter_assert.svh.
`include "subsequence_occurrence_counter_assert.svh"

module soc_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  soc_pkg::count_type  rsp_occurrence_count
);

   // A result that is held back stays offered.
   `SOC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")

   // A result that is held back keeps its value.
   `SOC_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_occurrence_count), "result changed while stalled")

   // The block works on one item at a time, so it stalls right after taking one.
   `SOC_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "item taken while busy")

   // A count never exceeds the largest binomial coefficient for 16 bits.
   `SOC_ASSERT_SAME(a_count_range, rsp_valid, rsp_occurrence_count <= 14'd12870, "count out of range")

endmodule

bind subsequence_occurrence_counter soc_checker u_soc_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_occurrence_count (rsp_occurrence_count)
);
